// ----- hw/rtl/lbgb_pkg.sv -----
`timescale 1ns / 1ps
package lbgb_pkg;

    localparam int COORD_W = 18;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int CELL_W  = 12;
    localparam int CNT_W   = 10;
    localparam int LIM_W   = 13;
    localparam int H_W     = 12;
    localparam int REFL_W  = 8;
    localparam int RAISE_W = 16;
    localparam int IDX_X_W = 9;
    localparam int IDX_Y_W = 9;
    localparam int IDX_Z_W = 3;
    localparam int CFG_IDX_W = 3;

    // column word layout: top height, top reflectance, raise count, then layers
    localparam int TOP_H_LSB  = 0;
    localparam int TOP_R_LSB  = TOP_H_LSB + H_W;
    localparam int RAISE_LSB  = TOP_R_LSB + REFL_W;
    localparam int LAYER_LSB  = RAISE_LSB + RAISE_W;

    localparam logic [H_W-1:0]     H_MAX     = '1;
    localparam logic [RAISE_W-1:0] RAISE_MAX = '1;

    typedef enum logic [0:0] {
        OP_BIN   = 1'b0,
        OP_CLEAR = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_ORIGIN = 3'd0,
        CFG_Y_ORIGIN = 3'd1,
        CFG_Z_ORIGIN = 3'd2,
        CFG_X_CELL   = 3'd3,
        CFG_Y_CELL   = 3'd4,
        CFG_Z_CELL   = 3'd5,
        CFG_X_CELLS  = 3'd6,
        CFG_Y_CELLS  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               in_grid;
        logic [IDX_X_W-1:0] cell_x;
        logic [IDX_Y_W-1:0] cell_y;
        logic [IDX_Z_W-1:0] cell_z;
        logic               layer_raised;
        logic [H_W-1:0]     height_mm;
        logic               top_raised;
        logic [REFL_W-1:0]  top_reflectance;
        logic [RAISE_W-1:0] raise_count;
        logic               clear_done;
    } t_result;

endpackage

// ----- hw/rtl/lbgb_ram.sv -----
`timescale 1ns / 1ps
module lbgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/lbgb_div.sv -----
`timescale 1ns / 1ps
module lbgb_div
    import lbgb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COORD_W-1:0] i_dividend,
    input  logic [CELL_W-1:0]  i_divisor,
    output logic               o_done,
    output logic [COORD_W-1:0] o_quot
);
    localparam int STEP_W = $clog2(COORD_W + 1);

    logic [STEP_W-1:0]  r_cnt;
    logic               r_done;
    logic [COORD_W-1:0] r_quot;
    logic [CELL_W-1:0]  r_rem;
    logic [CELL_W-1:0]  r_div;
    logic [CELL_W:0]    w_trial;
    logic [CELL_W:0]    w_diff;
    logic               w_ge;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quot[COORD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= STEP_W'(COORD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[COORD_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[CELL_W-1:0] : w_trial[CELL_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ----- hw/rtl/lidar_bev_grid_binner_unit.sv -----
`timescale 1ns / 1ps
// A bin request runs the three axis quotients through 18-step bit-serial dividers,
// then reads, modifies and writes back the column word (a point outside the grid
// skips the memory access). A new request is taken only in the idle state, once the
// last result has moved to the output register. A clear request sweeps every column
// to zero. Reset restores the register defaults and runs the same zeroing sweep
// first.
module lidar_bev_grid_binner_unit
    import lbgb_pkg::*;
#(
    parameter int MAX_COLUMNS = 512,
    parameter int MAX_ROWS    = 512,
    parameter int LAYERS      = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data,
    // point requests
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic [COORD_W-1:0]   i_x_mm,
    input  logic [COORD_W-1:0]   i_y_mm,
    input  logic [COORD_W-1:0]   i_z_mm,
    input  logic [REFL_W-1:0]    i_reflectance,
    // results
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_in_grid,
    output logic [IDX_X_W-1:0]   o_cell_x,
    output logic [IDX_Y_W-1:0]   o_cell_y,
    output logic [IDX_Z_W-1:0]   o_cell_z,
    output logic                 o_layer_raised,
    output logic [H_W-1:0]       o_height_mm,
    output logic                 o_top_raised,
    output logic [REFL_W-1:0]    o_top_reflectance,
    output logic [RAISE_W-1:0]   o_raise_count,
    output logic                 o_clear_done
);
    // one memory word per column: top fields plus all layer heights
    localparam int COLS   = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W = $clog2(COLS);
    localparam int WORD_W = LAYER_LSB + LAYERS * H_W;
    localparam int LZ_W   = (LAYERS > 1) ? $clog2(LAYERS) : 1;

    localparam logic [LIM_W-1:0]  X_MAX = LIM_W'(MAX_COLUMNS);
    localparam logic [LIM_W-1:0]  Y_MAX = LIM_W'(MAX_ROWS);
    localparam logic [LIM_W-1:0]  Z_LIM = LIM_W'(LAYERS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(COLS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_MODIFY,
        S_RESULT
    } t_state;

    t_state r_state;

    // configuration registers
    logic signed [COORD_W-1:0] r_x_org, r_y_org, r_z_org;
    logic [CELL_W-1:0]         r_x_cell, r_y_cell, r_z_cell;
    logic [CNT_W-1:0]          r_x_cells, r_y_cells;

    // per-request working registers
    logic                r_neg_x, r_neg_y, r_neg_z;
    logic [COORD_W-1:0]  r_mag_x, r_mag_y, r_mag_z;
    logic [H_W-1:0]      r_h;
    logic [REFL_W-1:0]   r_refl;
    logic [ADDR_W-1:0]   r_addr;
    logic [LZ_W-1:0]     r_cz;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic                r_clr_report;
    t_result             r_res;
    t_result             r_out;
    logic                r_out_valid;

    logic signed [DIFF_W-1:0] w_dx, w_dy, w_dz;
    logic [COORD_W-1:0]  w_mx, w_my, w_mz;
    logic                w_accept, w_start;
    logic                w_done_x, w_done_y, w_done_z;
    logic [COORD_W-1:0]  w_qx, w_qy, w_qz;
    logic [COORD_W-1:0]  w_ex, w_ey, w_ez;
    logic                w_ok;
    logic [LIM_W-1:0]    w_xlim, w_ylim;
    logic [ADDR_W-1:0]   w_col_addr;
    logic [H_W-1:0]      w_h;
    logic                w_mem_we, w_mem_re;
    logic [ADDR_W-1:0]   w_waddr;
    logic [WORD_W-1:0]   w_wdata, w_rdata, w_new;
    logic [H_W-1:0]      w_old_layer, w_old_top;
    logic [RAISE_W-1:0]  w_old_cnt;
    logic                w_lay_up, w_top_up;
    logic                w_out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_start     = w_accept && (t_opcode'(i_opcode) == OP_BIN);
    assign w_out_free  = !r_out_valid || i_out_ready;

    // offsets from the grid origin, split into sign and magnitude
    assign w_dx = DIFF_W'($signed(i_x_mm)) - DIFF_W'(r_x_org);
    assign w_dy = DIFF_W'($signed(i_y_mm)) - DIFF_W'(r_y_org);
    assign w_dz = DIFF_W'($signed(i_z_mm)) - DIFF_W'(r_z_org);
    assign w_mx = w_dx[DIFF_W-1] ? COORD_W'(-w_dx) : w_dx[COORD_W-1:0];
    assign w_my = w_dy[DIFF_W-1] ? COORD_W'(-w_dy) : w_dy[COORD_W-1:0];
    assign w_mz = w_dz[DIFF_W-1] ? COORD_W'(-w_dz) : w_dz[COORD_W-1:0];

    // saturate height to 0..4095
    always_comb begin
        if (w_dz[DIFF_W-1]) begin
            w_h = '0;
        end else if (w_dz > DIFF_W'(H_MAX)) begin
            w_h = H_MAX;
        end else begin
            w_h = w_dz[H_W-1:0];
        end
    end

    // one divider lane per axis; all three start and finish together
    lbgb_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_dividend(w_mx), .i_divisor(r_x_cell), .o_done(w_done_x), .o_quot(w_qx)
    );
    lbgb_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_dividend(w_my), .i_divisor(r_y_cell), .o_done(w_done_y), .o_quot(w_qy)
    );
    lbgb_div u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_dividend(w_mz), .i_divisor(r_z_cell), .o_done(w_done_z), .o_quot(w_qz)
    );

    // a small negative offset truncates to index 0
    assign w_ex = r_neg_x ? '0 : w_qx;
    assign w_ey = r_neg_y ? '0 : w_qy;
    assign w_ez = r_neg_z ? '0 : w_qz;

    assign w_xlim = (LIM_W'(r_x_cells) < X_MAX) ? LIM_W'(r_x_cells) : X_MAX;
    assign w_ylim = (LIM_W'(r_y_cells) < Y_MAX) ? LIM_W'(r_y_cells) : Y_MAX;

    function automatic logic axis_ok(
        input logic               neg,
        input logic [COORD_W-1:0] mag,
        input logic [COORD_W-1:0] q,
        input logic [CELL_W-1:0]  cell_size,
        input logic [LIM_W-1:0]   lim
    );
        logic in_cell;
        in_cell = !neg || (mag < COORD_W'(cell_size));
        return (cell_size != '0) && in_cell && (q < COORD_W'(lim));
    endfunction

    assign w_ok = axis_ok(r_neg_x, r_mag_x, w_ex, r_x_cell, w_xlim)
               && axis_ok(r_neg_y, r_mag_y, w_ey, r_y_cell, w_ylim)
               && axis_ok(r_neg_z, r_mag_z, w_ez, r_z_cell, Z_LIM);

    assign w_col_addr = ADDR_W'(w_ex) * ADDR_W'(MAX_ROWS) + ADDR_W'(w_ey);

    // column memory: sweep writes zeros, modify writes back the updated word
    assign w_mem_re = (r_state == S_READ);
    assign w_mem_we = (r_state == S_CLEAR) || (r_state == S_MODIFY);
    assign w_waddr  = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign w_wdata  = (r_state == S_CLEAR) ? '0 : w_new;

    lbgb_ram #(
        .WIDTH(WORD_W),
        .DEPTH(COLS)
    ) u_col_mem (
        .i_clk  (i_clk),
        .i_we   (w_mem_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_mem_re),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    // raise the layer and column top only on a strictly greater height
    assign w_old_layer = w_rdata[LAYER_LSB + int'(r_cz) * H_W +: H_W];
    assign w_old_top   = w_rdata[TOP_H_LSB +: H_W];
    assign w_old_cnt   = w_rdata[RAISE_LSB +: RAISE_W];
    assign w_lay_up    = r_h > w_old_layer;
    assign w_top_up    = r_h > w_old_top;

    always_comb begin
        w_new = w_rdata;
        if (w_lay_up) begin
            w_new[LAYER_LSB + int'(r_cz) * H_W +: H_W] = r_h;
        end
        if (w_top_up) begin
            w_new[TOP_H_LSB +: H_W]    = r_h;
            w_new[TOP_R_LSB +: REFL_W] = r_refl;
            if (w_old_cnt != RAISE_MAX) begin
                w_new[RAISE_LSB +: RAISE_W] = w_old_cnt + 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_org   <= COORD_W'(0);
            r_y_org   <= -COORD_W'(20000);
            r_z_org   <= -COORD_W'(2000);
            r_x_cell  <= CELL_W'(100);
            r_y_cell  <= CELL_W'(100);
            r_z_cell  <= CELL_W'(400);
            r_x_cells <= CNT_W'(401);
            r_y_cells <= CNT_W'(401);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_X_ORIGIN: r_x_org   <= i_cfg_data;
                CFG_Y_ORIGIN: r_y_org   <= i_cfg_data;
                CFG_Z_ORIGIN: r_z_org   <= i_cfg_data;
                CFG_X_CELL:   r_x_cell  <= i_cfg_data[CELL_W-1:0];
                CFG_Y_CELL:   r_y_cell  <= i_cfg_data[CELL_W-1:0];
                CFG_Z_CELL:   r_z_cell  <= i_cfg_data[CELL_W-1:0];
                CFG_X_CELLS:  r_x_cells <= i_cfg_data[CNT_W-1:0];
                CFG_Y_CELLS:  r_y_cells <= i_cfg_data[CNT_W-1:0];
                default:      r_x_cells <= r_x_cells;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_clr_report <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // raise valid when a result lands, drop it once the consumer takes it
            if (r_state == S_RESULT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= (r_clr_addr == LAST_ADDR) ? '0 : r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= r_clr_report ? S_RESULT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (t_opcode'(i_opcode) == OP_CLEAR) begin
                            r_clr_report <= 1'b1;
                            r_state      <= S_CLEAR;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_done_x) begin
                        r_state <= w_ok ? S_READ : S_RESULT;
                    end
                end
                S_READ: begin
                    r_state <= S_MODIFY;
                end
                S_MODIFY: begin
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    // hold the result until the output register frees up
                    if (w_out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg_x <= w_dx[DIFF_W-1];
            r_neg_y <= w_dy[DIFF_W-1];
            r_neg_z <= w_dz[DIFF_W-1];
            r_mag_x <= w_mx;
            r_mag_y <= w_my;
            r_mag_z <= w_mz;
            r_h     <= w_h;
            r_refl  <= i_reflectance;
            // clear_done is the lowest field; everything else starts at zero
            r_res   <= {{($bits(t_result) - 1){1'b0}}, (t_opcode'(i_opcode) == OP_CLEAR)};
        end
        if (r_state == S_DIV && w_done_x) begin
            r_addr <= w_col_addr;
            r_cz   <= w_ez[LZ_W-1:0];
        end
        if (r_state == S_MODIFY) begin
            r_res.in_grid         <= 1'b1;
            r_res.cell_x          <= w_ex[IDX_X_W-1:0];
            r_res.cell_y          <= w_ey[IDX_Y_W-1:0];
            r_res.cell_z          <= w_ez[IDX_Z_W-1:0];
            r_res.height_mm       <= r_h;
            r_res.layer_raised    <= w_lay_up;
            r_res.top_raised      <= w_top_up;
            r_res.top_reflectance <= w_new[TOP_R_LSB +: REFL_W];
            r_res.raise_count     <= w_new[RAISE_LSB +: RAISE_W];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_in_grid         = r_out.in_grid;
    assign o_cell_x          = r_out.cell_x;
    assign o_cell_y          = r_out.cell_y;
    assign o_cell_z          = r_out.cell_z;
    assign o_layer_raised    = r_out.layer_raised;
    assign o_height_mm       = r_out.height_mm;
    assign o_top_raised      = r_out.top_raised;
    assign o_top_reflectance = r_out.top_reflectance;
    assign o_raise_count     = r_out.raise_count;
    assign o_clear_done      = r_out.clear_done;

    // the column top bounds every layer height, so a top raise implies a layer raise
    a_top_implies_layer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_top_raised) |-> o_layer_raised)
        else $error("top raised without layer raise");

    a_clear_no_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clear_done) |-> !o_in_grid)
        else $error("clear result flagged in grid");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done_x == w_done_y) && (w_done_x == w_done_z))
        else $error("divider lanes out of step");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_mem_we)
        else $error("memory write while idle");

    a_modify_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MODIFY) |-> $past(w_mem_re))
        else $error("write-back without a prior read");
endmodule

// ----- bench/grid_binner_checker.sv -----
`timescale 1ns / 1ps
module grid_binner_checker
    import lbgb_pkg::*;
#(
    parameter int MAX_COLUMNS = 512,
    parameter int MAX_ROWS    = 512,
    parameter int LAYERS      = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic [COORD_W-1:0]   i_x_mm,
    input  logic [COORD_W-1:0]   i_y_mm,
    input  logic [COORD_W-1:0]   i_z_mm,
    input  logic [REFL_W-1:0]    i_reflectance,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic                 o_in_grid,
    input  logic [IDX_X_W-1:0]   o_cell_x,
    input  logic [IDX_Y_W-1:0]   o_cell_y,
    input  logic [IDX_Z_W-1:0]   o_cell_z,
    input  logic                 o_layer_raised,
    input  logic [H_W-1:0]       o_height_mm,
    input  logic                 o_top_raised,
    input  logic [REFL_W-1:0]    o_top_reflectance,
    input  logic [RAISE_W-1:0]   o_raise_count,
    input  logic                 o_clear_done,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_grid_hits
);

    logic signed [COORD_W-1:0] x_org, y_org, z_org;
    logic [CELL_W-1:0]         x_cell, y_cell, z_cell;
    logic [CNT_W-1:0]          x_cnt, y_cnt;

    logic [H_W-1:0]     layer_peak [int];
    logic [H_W-1:0]     column_peak [int];
    logic [REFL_W-1:0]  column_refl [int];
    logic [RAISE_W-1:0] column_raises [int];

    t_result expected_bins [$];
    t_result want, got;
    int      errors = 0;
    int      hits = 0;
    int      issued = 0;
    int      retired = 0;

    assign o_errors    = errors;
    assign o_pending   = issued - retired;
    assign o_grid_hits = hits;

    function automatic bit axis_index(input int coord, input int org, input int cell_size,
                                      input int lim, output int idx);
        int d;
        d   = coord - org;
        idx = 0;
        if (cell_size == 0) return 1'b0;
        if (d < 0) begin
            if (-d >= cell_size) return 1'b0;
        end else begin
            idx = d / cell_size;
        end
        return idx < lim;
    endfunction

    function automatic t_result bin_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                          input logic [COORD_W-1:0] z, input logic [REFL_W-1:0] r);
        int cx, cy, cz, col, lay, dz, xl, yl;
        logic [H_W-1:0]     h, old;
        logic [RAISE_W-1:0] cnt;
        t_result            res;
        res = '0;
        xl  = (x_cnt < MAX_COLUMNS) ? int'(x_cnt) : MAX_COLUMNS;
        yl  = (y_cnt < MAX_ROWS) ? int'(y_cnt) : MAX_ROWS;
        if (!axis_index(int'($signed(x)), int'(x_org), int'(x_cell), xl, cx) ||
            !axis_index(int'($signed(y)), int'(y_org), int'(y_cell), yl, cy) ||
            !axis_index(int'($signed(z)), int'(z_org), int'(z_cell), LAYERS, cz))
            return res;
        dz = int'($signed(z)) - int'(z_org);
        // saturate height to the 12-bit store range
        h  = (dz < 0) ? '0 : (dz > 4095) ? H_MAX : dz[H_W-1:0];
        col = cx * MAX_ROWS + cy;
        lay = col * LAYERS + cz;
        res.in_grid   = 1'b1;
        res.cell_x    = cx[IDX_X_W-1:0];
        res.cell_y    = cy[IDX_Y_W-1:0];
        res.cell_z    = cz[IDX_Z_W-1:0];
        res.height_mm = h;
        old = layer_peak.exists(lay) ? layer_peak[lay] : '0;
        if (h > old) begin
            layer_peak[lay]    = h;
            res.layer_raised = 1'b1;
        end
        old = column_peak.exists(col) ? column_peak[col] : '0;
        if (h > old) begin
            column_peak[col] = h;
            column_refl[col] = r;
            cnt = column_raises.exists(col) ? column_raises[col] : '0;
            if (cnt != RAISE_MAX) cnt++;
            column_raises[col] = cnt;
            res.top_raised     = 1'b1;
        end
        res.top_reflectance = column_refl.exists(col) ? column_refl[col] : '0;
        res.raise_count     = column_raises.exists(col) ? column_raises[col] : '0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            x_org  = '0;
            y_org  = -18'sd20000;
            z_org  = -18'sd2000;
            x_cell = 12'd100;
            y_cell = 12'd100;
            z_cell = 12'd400;
            x_cnt  = 10'd401;
            y_cnt  = 10'd401;
            layer_peak.delete();
            column_peak.delete();
            column_refl.delete();
            column_raises.delete();
            expected_bins.delete();
        end else begin
            // retire the oldest expectation first; a request taken this edge cannot answer yet
            if (o_out_valid && i_out_ready) begin
                got = {o_in_grid, o_cell_x, o_cell_y, o_cell_z, o_layer_raised, o_height_mm,
                       o_top_raised, o_top_reflectance, o_raise_count, o_clear_done};
                if (expected_bins.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", got);
                end else begin
                    want = expected_bins.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("result %0d mismatch: expected %p, got %p",
                                     retired, want, got);
                    end
                end
                retired <= retired + 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_X_ORIGIN: x_org  = i_cfg_data;
                    CFG_Y_ORIGIN: y_org  = i_cfg_data;
                    CFG_Z_ORIGIN: z_org  = i_cfg_data;
                    CFG_X_CELL:   x_cell = i_cfg_data[CELL_W-1:0];
                    CFG_Y_CELL:   y_cell = i_cfg_data[CELL_W-1:0];
                    CFG_Z_CELL:   z_cell = i_cfg_data[CELL_W-1:0];
                    CFG_X_CELLS:  x_cnt  = i_cfg_data[CNT_W-1:0];
                    CFG_Y_CELLS:  y_cnt  = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                if (t_opcode'(i_opcode) == OP_CLEAR) begin
                    layer_peak.delete();
                    column_peak.delete();
                    column_refl.delete();
                    column_raises.delete();
                    want = '0;
                    want.clear_done = 1'b1;
                end else begin
                    want = bin_point(i_x_mm, i_y_mm, i_z_mm, i_reflectance);
                    if (want.in_grid) hits++;
                end
                expected_bins.insert(expected_bins.size(), want);
                issued <= issued + 1;
            end
        end
    end

endmodule

// ----- bench/tb_lidar_bev_grid_binner_unit.sv -----
`timescale 1ns / 1ps
module tb_lidar_bev_grid_binner_unit;
    import lbgb_pkg::*;

    localparam int LAYERS = 7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COORD_W-1:0]   i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_opcode = 1'b0;
    logic [COORD_W-1:0]   i_x_mm = '0;
    logic [COORD_W-1:0]   i_y_mm = '0;
    logic [COORD_W-1:0]   i_z_mm = '0;
    logic [REFL_W-1:0]    i_reflectance = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_grid;
    logic [IDX_X_W-1:0]   o_cell_x;
    logic [IDX_Y_W-1:0]   o_cell_y;
    logic [IDX_Z_W-1:0]   o_cell_z;
    logic                 o_layer_raised;
    logic [H_W-1:0]       o_height_mm;
    logic                 o_top_raised;
    logic [REFL_W-1:0]    o_top_reflectance;
    logic [RAISE_W-1:0]   o_raise_count;
    logic                 o_clear_done;

    int errors, pending, grid_hits;

    // grid setting as last written, used to aim points at the grid
    int org [3];
    int cell_mm [3];
    int cnt [2];

    int burst_left = 0;
    int n_points = 0;
    int n_clears = 0;
    int n_settings = 1;
    int ready_cycle = 0;
    int ready_mode = 0;

    always #6 i_clk = ~i_clk;

    lidar_bev_grid_binner_unit u_top (.*);

    grid_binner_checker u_checker (
        .*,
        .o_errors   (errors),
        .o_pending  (pending),
        .o_grid_hits(grid_hits)
    );

    // receiver: rotate through always ready, coin-flip, and long stalls
    always @(posedge i_clk) begin
        ready_cycle <= ready_cycle + 1;
        if (ready_cycle % 150 == 0) ready_mode <= $urandom_range(0, 2);
        case (ready_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= (ready_cycle % 9 == 0);
        endcase
    end

    // hold the request until taken; gaps fall between bursts only
    task automatic send_request(input t_opcode op, input int x, input int y, input int z,
                                input int r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_x_mm        <= x[COORD_W-1:0];
        i_y_mm        <= y[COORD_W-1:0];
        i_z_mm        <= z[COORD_W-1:0];
        i_reflectance <= r[REFL_W-1:0];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op == OP_CLEAR) n_clears++;
        else n_points++;
    endtask

    // drop valid and wait until every outstanding request has answered
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[COORD_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_grid(input int xo, input int yo, input int zo, input int xc,
                            input int yc, input int zc, input int xn, input int yn);
        drain();
        cfg_write(CFG_X_ORIGIN, xo);
        cfg_write(CFG_Y_ORIGIN, yo);
        cfg_write(CFG_Z_ORIGIN, zo);
        cfg_write(CFG_X_CELL, xc);
        cfg_write(CFG_Y_CELL, yc);
        cfg_write(CFG_Z_CELL, zc);
        cfg_write(CFG_X_CELLS, xn);
        cfg_write(CFG_Y_CELLS, yn);
        i_cfg_valid <= 1'b0;
        org     = '{xo, yo, zo};
        cell_mm = '{xc, yc, zc};
        cnt     = '{xn, yn};
        n_settings++;
    endtask

    // mostly points aimed at the grid (with column revisits), some full-range noise
    task automatic random_points(input int n, input bit with_clear);
        int xv, yv, zv;
        xv = org[0];
        yv = org[1];
        for (int i = 0; i < n; i++) begin
            if (with_clear && i == n / 2) begin
                send_request(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
            end else if ($urandom_range(0, 9) < 2) begin
                send_request(OP_BIN, $urandom, $urandom, $urandom, $urandom);
            end else begin
                if ($urandom_range(0, 9) >= 3) begin
                    xv = org[0] - cell_mm[0] + $urandom_range(0, cell_mm[0] * (cnt[0] + 2));
                    yv = org[1] - cell_mm[1] + $urandom_range(0, cell_mm[1] * (cnt[1] + 2));
                end
                zv = org[2] - cell_mm[2] + $urandom_range(0, cell_mm[2] * (LAYERS + 2));
                send_request(OP_BIN, xv, yv, zv, $urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        org     = '{0, -20000, -2000};
        cell_mm = '{100, 100, 400};
        cnt     = '{401, 401};

        // directed: reset grid, corners, edges, height ordering, clear
        send_request(OP_BIN, 0, -20000, -2000, 0);
        send_request(OP_BIN, -99, -20000, -1900, 255);
        send_request(OP_BIN, -100, 0, 0, 1);
        send_request(OP_BIN, 40099, 20099, 799, 200);
        send_request(OP_BIN, 40100, 0, 0, 3);
        send_request(OP_BIN, 0, 20100, 0, 4);
        send_request(OP_BIN, 0, 0, 800, 5);
        send_request(OP_BIN, 0, 0, -2001, 6);
        send_request(OP_BIN, 0, 0, -2400, 7);
        send_request(OP_BIN, 1000, 0, -1000, 10);
        send_request(OP_BIN, 1000, 0, -1000, 20);
        send_request(OP_BIN, 1000, 0, -1500, 30);
        send_request(OP_BIN, 1000, 0, -900, 40);
        send_request(OP_BIN, -131072, -131072, -131072, 0);
        send_request(OP_BIN, 131071, 131071, 131071, 255);
        send_request(OP_CLEAR, 131071, -131072, 131071, 255);
        send_request(OP_BIN, 1000, 0, -1500, 50);
        send_request(OP_BIN, 1050, 50, -1201, 60);
        random_points(180, 1'b0);

        // widest cells, full grid, lowest origins: heights saturate
        set_grid(-131072, -131072, -131072, 4095, 4095, 4095, 512, 512);
        random_points(200, 1'b0);

        // narrowest everything at the top of the coordinate range
        set_grid(131071, 131071, 131071, 1, 1, 1, 1, 1);
        random_points(150, 1'b0);

        // small random grid with frequent column revisits and one mid-run clear
        set_grid($urandom_range(0, 10000) - 5000, $urandom_range(0, 10000) - 5000,
                 $urandom_range(0, 10000) - 5000, $urandom_range(1, 300),
                 $urandom_range(1, 300), $urandom_range(1, 300),
                 $urandom_range(1, 12), $urandom_range(1, 12));
        random_points(250, 1'b1);

        // fully random setting
        set_grid($urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072,
                 $urandom_range(0, 262143) - 131072, $urandom_range(1, 4095),
                 $urandom_range(1, 4095), $urandom_range(1, 4095),
                 $urandom_range(1, 512), $urandom_range(1, 512));
        random_points(200, 1'b0);

        drain();
        // let any stray result surface
        repeat (40) @(posedge i_clk);
        $display("Sent %0d points and %0d clears across %0d grid settings.",
                 n_points, n_clears, n_settings);
        $display("%0d points landed in the grid; %0d mismatches.", grid_hits, errors);
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- lidar_bev_grid_binner_unit.f -----
hw/rtl/lbgb_pkg.sv
hw/rtl/lbgb_ram.sv
hw/rtl/lbgb_div.sv
hw/rtl/lidar_bev_grid_binner_unit.sv
bench/grid_binner_checker.sv
bench/tb_lidar_bev_grid_binner_unit.sv
